[hdl/ssrr_pkg.sv]
// shared types and constants for the short-run remover
package ssrr_pkg;

    localparam int MAX_ACCEPT = 16;
    localparam int HELD_DEPTH = MAX_ACCEPT - 1;
    localparam int CNT_W      = $clog2(MAX_ACCEPT);
    localparam int IDX_W      = $clog2(HELD_DEPTH);
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 5;
    localparam int RUN_W      = 5;
    localparam int ACC_W      = $clog2(MAX_ACCEPT + 1);
    localparam int CMP_W      = (ACC_W > CFG_W) ? ACC_W : CFG_W;
    localparam int EXP_LSB    = 23;
    localparam int EXP_W      = 8;

    localparam logic [DATA_W-1:0] INF_BITS   = 32'h7F80_0000;
    localparam logic [CFG_W-1:0]  RESET_MIN  = 5'd3;
    localparam logic [RUN_W-1:0]  RUN_MAX    = {RUN_W{1'b1}};
    localparam logic [EXP_W-1:0]  EXP_ONES   = {EXP_W{1'b1}};

    typedef logic [CMP_W-1:0] t_cmp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_drain;
        logic load_item;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic has_drain;
        logic emit;
        logic drain_last;
        logic out_free;
    } t_status;

endpackage

[hdl/ssrr_ctrl.sv]
// controller: sequences accept, held-point drain and item emit
module ssrr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ssrr_pkg::t_status i_status,
    output ssrr_pkg::t_cmd    o_cmd
);

    ssrr_pkg::t_state r_state;
    ssrr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssrr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd.accept     = 1'b0;
        o_cmd.load_drain = 1'b0;
        o_cmd.load_item  = 1'b0;
        o_in_stall       = 1'b1;
        case (r_state)
            ssrr_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    if (i_status.has_drain) begin
                        n_state = ssrr_pkg::ST_DRAIN;
                    end else if (i_status.emit) begin
                        n_state = ssrr_pkg::ST_EMIT;
                    end
                end
            end
            ssrr_pkg::ST_DRAIN: begin
                if (i_status.out_free) begin
                    o_cmd.load_drain = 1'b1;
                    if (i_status.drain_last) begin
                        n_state = ssrr_pkg::ST_EMIT;
                    end
                end
            end
            ssrr_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ssrr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssrr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/ssrr_datapath.sv]
// datapath: run tracking, held-point store, config register and output register
module ssrr_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ssrr_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [ssrr_pkg::DATA_W-1:0]   i_range_bits,
    input  logic                          i_scan_end,
    input  ssrr_pkg::t_cmd                i_cmd,
    output ssrr_pkg::t_status             o_status,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [ssrr_pkg::DATA_W-1:0]   o_out_range_bits,
    output logic                          o_last_of_burst,
    output logic                          o_out_scan_end
);

    logic [ssrr_pkg::DATA_W-1:0] r_held [ssrr_pkg::HELD_DEPTH];

    logic [ssrr_pkg::CFG_W-1:0]  r_min_acc;
    logic [ssrr_pkg::RUN_W-1:0]  r_run_len;
    logic [ssrr_pkg::RUN_W-1:0]  n_run_len;
    logic                        r_run_acc;
    logic                        n_run_acc;
    logic [ssrr_pkg::CNT_W-1:0]  r_held_cnt;
    logic [ssrr_pkg::CNT_W-1:0]  n_held_cnt;

    logic [ssrr_pkg::CNT_W-1:0]  r_drain_cnt;
    logic [ssrr_pkg::IDX_W-1:0]  r_drain_idx;
    logic                        r_remove;
    logic [ssrr_pkg::DATA_W-1:0] r_item;
    logic                        r_item_end;

    logic                        r_out_valid;
    logic [ssrr_pkg::DATA_W-1:0] r_out_data;
    logic                        r_out_last;
    logic                        r_out_end;

    logic                        pt_ok;
    logic [ssrr_pkg::RUN_W-1:0]  run_inc;
    ssrr_pkg::t_cmp              min_eff;
    logic                        dec_drain;
    logic                        dec_remove;
    logic                        dec_emit;
    logic                        hold_wr;
    logic                        out_free;

    assign pt_ok   = i_range_bits[ssrr_pkg::EXP_LSB +: ssrr_pkg::EXP_W] != ssrr_pkg::EXP_ONES;
    assign run_inc = (r_run_len == ssrr_pkg::RUN_MAX) ? r_run_len
                                                      : r_run_len + 1'b1;
    // accept sizes above MAX_ACCEPT act as MAX_ACCEPT
    assign min_eff = (ssrr_pkg::t_cmp'(r_min_acc) > ssrr_pkg::t_cmp'(ssrr_pkg::MAX_ACCEPT))
                   ? ssrr_pkg::t_cmp'(ssrr_pkg::MAX_ACCEPT)
                   : ssrr_pkg::t_cmp'(r_min_acc);

    always_comb begin
        n_run_len  = r_run_len;
        n_run_acc  = r_run_acc;
        n_held_cnt = r_held_cnt;
        dec_drain  = 1'b0;
        dec_remove = 1'b0;
        dec_emit   = 1'b1;
        hold_wr    = 1'b0;
        if (pt_ok) begin
            n_run_len = run_inc;
            if (r_run_acc) begin
                dec_emit = 1'b1;
            end else if (ssrr_pkg::t_cmp'(run_inc) >= min_eff || i_scan_end) begin
                dec_drain  = 1'b1;
                n_held_cnt = '0;
                n_run_acc  = 1'b1;
            end else begin
                dec_emit = 1'b0;
                if (ssrr_pkg::t_cmp'(r_held_cnt) < ssrr_pkg::t_cmp'(ssrr_pkg::HELD_DEPTH)) begin
                    hold_wr    = 1'b1;
                    n_held_cnt = r_held_cnt + 1'b1;
                end
            end
        end else begin
            // invalid point ends the run; short runs get blanked
            dec_drain  = !r_run_acc;
            dec_remove = ssrr_pkg::t_cmp'(r_held_cnt) < min_eff;
            n_run_len  = '0;
            n_run_acc  = 1'b0;
            n_held_cnt = '0;
        end
        if (i_scan_end) begin
            n_run_len  = '0;
            n_run_acc  = 1'b0;
            n_held_cnt = '0;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.has_drain  = dec_drain && (r_held_cnt != '0);
    assign o_status.emit       = dec_emit;
    assign o_status.drain_last = ssrr_pkg::CNT_W'(r_drain_idx) == (r_drain_cnt - 1'b1);
    assign o_status.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_acc   <= ssrr_pkg::RESET_MIN;
            r_run_len   <= '0;
            r_run_acc   <= 1'b0;
            r_held_cnt  <= '0;
            r_drain_cnt <= '0;
            r_drain_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_acc <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_run_len   <= n_run_len;
                r_run_acc   <= n_run_acc;
                r_held_cnt  <= n_held_cnt;
                r_drain_cnt <= r_held_cnt;
                r_drain_idx <= '0;
            end else if (i_cmd.load_drain) begin
                r_drain_idx <= r_drain_idx + 1'b1;
            end
            if (i_cmd.load_drain || i_cmd.load_item) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_remove   <= dec_remove;
            r_item     <= i_range_bits;
            r_item_end <= i_scan_end;
            if (hold_wr) begin
                r_held[r_held_cnt[ssrr_pkg::IDX_W-1:0]] <= i_range_bits;
            end
        end
        if (i_cmd.load_drain) begin
            r_out_data <= r_remove ? ssrr_pkg::INF_BITS : r_held[r_drain_idx];
            r_out_last <= 1'b0;
            r_out_end  <= 1'b0;
        end else if (i_cmd.load_item) begin
            r_out_data <= r_item;
            r_out_last <= 1'b1;
            r_out_end  <= r_item_end;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_range_bits = r_out_data;
    assign o_last_of_burst  = r_out_last;
    assign o_out_scan_end   = r_out_end;

endmodule

[hdl/scan_short_run_remover_unit.sv]
// top level of the lidar short-run remover
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_range_bits,      | into block
//          | i_scan_end                                 |
//  out     | o_out_valid, i_out_stall, o_out_range_bits,| out of block
//          | o_last_of_burst, o_out_scan_end            |
//  cfg     | i_cfg_we, i_cfg_wdata (min accept size)    | into block
//
// a held point leaves the block ready; one that emits itself goes to ST_EMIT,
// via ST_DRAIN if it releases held points; unless stalled, the output register
// loads one result per cycle from the single read port of the held store.
// reset is synchronous, active low; the accept size returns to 3.
// a stall on the output holds the output register and pauses the drain;
// the next item is taken while the last result still waits.
module scan_short_run_remover_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ssrr_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ssrr_pkg::DATA_W-1:0]   i_range_bits,
    input  logic                          i_scan_end,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ssrr_pkg::DATA_W-1:0]   o_out_range_bits,
    output logic                          o_last_of_burst,
    output logic                          o_out_scan_end
);

    ssrr_pkg::t_cmd    cmd;
    ssrr_pkg::t_status status;

    ssrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ssrr_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_range_bits     (i_range_bits),
        .i_scan_end       (i_scan_end),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_out_range_bits (o_out_range_bits),
        .o_last_of_burst  (o_last_of_burst),
        .o_out_scan_end   (o_out_scan_end)
    );

    // the output register is only loaded when it has room
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_drain || cmd.load_item) |-> status.out_free)
        else $error("output register loaded while full and stalled");

    // an item that produces results keeps the input stalled next cycle
    a_busy_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && status.emit) |=> o_in_stall)
        else $error("input not stalled while results are pending");

    // a point that is only held leaves the block ready again
    a_ready_after_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && !status.emit && !status.has_drain) |=> !o_in_stall)
        else $error("block busy after a held point");

endmodule

[tb/ssrr_run_checker.sv]
// result checker for the short-run remover: predicts every result from the accepted items
module ssrr_run_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ssrr_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [ssrr_pkg::DATA_W-1:0] i_range_bits,
    input  logic                        i_scan_end,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [ssrr_pkg::DATA_W-1:0] i_out_range_bits,
    input  logic                        i_last_of_burst,
    input  logic                        i_out_scan_end,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_points,
    output int                          o_results
);

    localparam int REPORT_LINES = 30;
    localparam int RUN_SAT      = 31;

    typedef struct packed {
        logic [ssrr_pkg::DATA_W-1:0] bits;
        logic                        burst_end;
        logic                        scan_end;
    } t_point;

    t_point                      expected_points[$];
    logic [ssrr_pkg::DATA_W-1:0] held_run [ssrr_pkg::HELD_DEPTH];
    int                          held_n      = 0;
    int                          run_len     = 0;
    bit                          run_kept    = 1'b0;
    logic [ssrr_pkg::CFG_W-1:0]  accept_size = ssrr_pkg::RESET_MIN;
    int                          fails       = 0;
    int                          points      = 0;
    int                          results     = 0;

    task automatic report_mismatch(input string msg);
        fails++;
        if (fails <= REPORT_LINES)
            $display("mismatch at result %0d: %s", results, msg);
    endtask

    task automatic emit_point(input logic [ssrr_pkg::DATA_W-1:0] v);
        t_point p;
        p.bits      = v;
        p.burst_end = 1'b0;
        p.scan_end  = 1'b0;
        expected_points.insert(expected_points.size(), p);
    endtask

    task automatic release_run(input bit remove);
        for (int i = 0; i < held_n; i++)
            emit_point(remove ? ssrr_pkg::INF_BITS : held_run[i]);
        held_n = 0;
    endtask

    task automatic clear_run();
        held_n   = 0;
        run_len  = 0;
        run_kept = 1'b0;
    endtask

    task automatic filter_point(input logic [ssrr_pkg::DATA_W-1:0] x, input logic fin);
        int lim;
        int queued_n;
        lim      = (accept_size > ssrr_pkg::MAX_ACCEPT) ? ssrr_pkg::MAX_ACCEPT
                                                        : int'(accept_size);
        queued_n = expected_points.size();
        if (x[ssrr_pkg::EXP_LSB +: ssrr_pkg::EXP_W] != ssrr_pkg::EXP_ONES) begin
            if (run_len < RUN_SAT)
                run_len++;
            if (run_kept) begin
                emit_point(x);
            end else if (run_len >= lim || fin) begin
                release_run(1'b0);
                emit_point(x);
                run_kept = 1'b1;
            end else if (held_n < ssrr_pkg::HELD_DEPTH) begin
                held_run[held_n] = x;
                held_n++;
            end
        end else begin
            // a run cut short is replaced only while still below the accept size
            if (!run_kept && held_n > 0)
                release_run(held_n < lim);
            emit_point(x);
            clear_run();
        end
        if (fin)
            clear_run();
        if (expected_points.size() > queued_n) begin
            expected_points[expected_points.size() - 1].burst_end = 1'b1;
            expected_points[expected_points.size() - 1].scan_end  = fin;
        end
    endtask

    task automatic check_result();
        t_point want;
        results++;
        if (expected_points.size() == 0) begin
            report_mismatch($sformatf("result %h arrived with nothing expected",
                                      i_out_range_bits));
            return;
        end
        want = expected_points.pop_front();
        if (i_out_range_bits !== want.bits)
            report_mismatch($sformatf("range bits expected %h got %h",
                                      want.bits, i_out_range_bits));
        if (i_last_of_burst !== want.burst_end)
            report_mismatch($sformatf("last_of_burst expected %b got %b",
                                      want.burst_end, i_last_of_burst));
        if (i_out_scan_end !== want.scan_end)
            report_mismatch($sformatf("out_scan_end expected %b got %b",
                                      want.scan_end, i_out_scan_end));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_points.delete();
            clear_run();
            accept_size = ssrr_pkg::RESET_MIN;
        end else begin
            if (i_cfg_we)
                accept_size = i_cfg_wdata;
            // predict before comparing so a same-edge item queues behind older results
            if (i_in_valid && !i_in_stall) begin
                filter_point(i_range_bits, i_scan_end);
                points++;
            end
            if (i_out_valid && !i_out_stall)
                check_result();
        end
        o_fail_count <= fails;
        o_pending    <= expected_points.size();
        o_points     <= points;
        o_results    <= results;
    end

endmodule

[tb/scan_short_run_remover_unit_tb.sv]
// testbench top for the short-run remover: stimulus, idling, watchdog and verdict
module scan_short_run_remover_unit_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_POINTS   = 60;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        cfg_we;
    logic [ssrr_pkg::CFG_W-1:0]  cfg_wdata;
    logic                        in_valid;
    logic                        in_stall;
    logic [ssrr_pkg::DATA_W-1:0] range_bits;
    logic                        scan_end;
    logic                        out_valid;
    logic                        out_stall;
    logic [ssrr_pkg::DATA_W-1:0] out_range_bits;
    logic                        last_of_burst;
    logic                        out_scan_end;

    int fail_count;
    int pending_count;
    int point_count;
    int result_count;
    int idle_cycles = 0;
    int settings    = 0;
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    bit hold_req    = 1'b0;

    scan_short_run_remover_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_range_bits     (range_bits),
        .i_scan_end       (scan_end),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_out_range_bits (out_range_bits),
        .o_last_of_burst  (last_of_burst),
        .o_out_scan_end   (out_scan_end)
    );

    ssrr_run_checker run_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_range_bits     (range_bits),
        .i_scan_end       (scan_end),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_range_bits (out_range_bits),
        .i_last_of_burst  (last_of_burst),
        .i_out_scan_end   (out_scan_end),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count),
        .o_points         (point_count),
        .o_results        (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ssrr_pkg::DATA_W-1:0] valid_point();
        logic [ssrr_pkg::DATA_W-1:0] x;
        case ($urandom_range(15))
            0: x = 32'h0000_0000;
            1: x = 32'h8000_0000;
            2: x = 32'h7F7F_FFFF;
            3: x = 32'hFF7F_FFFF;
            default: begin
                x = $urandom;
                if (x[ssrr_pkg::EXP_LSB +: ssrr_pkg::EXP_W] == ssrr_pkg::EXP_ONES)
                    x[ssrr_pkg::EXP_LSB] = 1'b0;
            end
        endcase
        return x;
    endfunction

    function automatic logic [ssrr_pkg::DATA_W-1:0] invalid_point();
        logic [ssrr_pkg::DATA_W-1:0] x;
        x = $urandom;
        x[ssrr_pkg::EXP_LSB +: ssrr_pkg::EXP_W] = ssrr_pkg::EXP_ONES;
        if ($urandom_range(2) == 0)
            x[ssrr_pkg::EXP_LSB-1:0] = '0;
        return x;
    endfunction

    task automatic send_point(input logic [ssrr_pkg::DATA_W-1:0] x, input logic fin);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        range_bits <= x;
        scan_end   <= fin;
        do @(posedge i_clk); while (in_stall);
    endtask

    // len valid points, then optionally an invalid one; scan end on the last item if fin
    task automatic send_run(input int len, input bit close, input bit fin);
        for (int i = 0; i < len; i++)
            send_point(valid_point(), fin && !close && i == len - 1);
        if (close)
            send_point(invalid_point(), fin);
    endtask

    task automatic random_points(input int target);
        int sent;
        int r;
        int len;
        bit close;
        sent = 0;
        while (sent < target) begin
            r = $urandom_range(99);
            if (r < 85) begin
                len   = (r < 10) ? $urandom_range(17, 40) : $urandom_range(0, 17);
                if (len > target - sent)
                    len = target - sent;
                close = $urandom_range(9) != 0;
                send_run(len, close, $urandom_range(11) == 0);
                sent += len + int'(close);
            end else begin
                // noise: any raw pattern, scan end now and then
                send_point($urandom, $urandom_range(7) == 0);
                sent++;
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_accept(input logic [ssrr_pkg::CFG_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        settings++;
    endtask

    // output side: random stalls, plus one long hold on request
    initial begin
        out_stall = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                int n;
                n = pick_gap(rx_quiet);
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_count);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        range_bits = '0;
        scan_end   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset accept size of three
        send_run(2, 1'b1, 1'b0);
        send_point(32'h0000_0000, 1'b0);
        send_point(32'h8000_0000, 1'b0);
        send_point(32'h7F7F_FFFF, 1'b0);
        send_point(32'hFF7F_FFFF, 1'b0);
        send_point(32'hFFFF_FFFF, 1'b0);
        send_point(ssrr_pkg::INF_BITS, 1'b0);
        send_point(32'hFF80_0000, 1'b0);
        send_run(2, 1'b0, 1'b1);
        send_run(1, 1'b0, 1'b1);
        send_point(valid_point(), 1'b0);
        send_point(32'h7FC0_0001, 1'b1);
        send_point(32'h7F80_0001, 1'b1);

        // accept size lowered while a run is held
        write_accept(5'd5);
        send_run(3, 1'b0, 1'b0);
        write_accept(5'd2);
        send_point(valid_point(), 1'b0);
        send_point(invalid_point(), 1'b0);
        write_accept(5'd6);
        send_run(3, 1'b0, 1'b0);
        write_accept(5'd2);
        send_point(invalid_point(), 1'b0);

        // largest effective accept size, with the output held off while items keep coming
        write_accept(5'd16);
        hold_req = 1'b1;
        tx_quiet = 1'b1;
        random_points(40);
        tx_quiet = 1'b0;
        random_points(PHASE_POINTS - 40);

        write_accept(5'd0);
        rx_quiet = 1'b1;
        random_points(PHASE_POINTS / 2);
        rx_quiet = 1'b0;
        random_points(PHASE_POINTS / 2);

        write_accept(5'd31);
        random_points(PHASE_POINTS);

        write_accept(5'd1);
        tx_quiet = 1'b1;
        random_points(PHASE_POINTS / 2);
        tx_quiet = 1'b0;
        random_points(PHASE_POINTS / 2);

        write_accept(5'($urandom_range(2, 15)));
        random_points(PHASE_POINTS);

        write_accept(5'd5);
        random_points(PHASE_POINTS);

        settle();
        $display("run summary: %0d points sent, %0d results checked, %0d accept-size writes",
                 point_count, result_count, settings);
        $display("covered short-run removal and release, mid-run scan ends, a %0d-cycle hold",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
